@@ hdl/gwt_pkg.sv @@
// shared widths, item codes and the queue entry type for the weighted threshold block
`timescale 1ns / 1ps
package gwt_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int GRAD_BITS  = 16;
	localparam int COUNT_BITS = 20;

	// port widths of the payload fields
	localparam int KIND_W = 2;
	localparam int PIX_W  = 16;
	localparam int GRAD_W = 16;

	// sums saturate at 64 bits at most
	localparam int WSUM_FULL = PIXEL_BITS + GRAD_BITS + COUNT_BITS;
	localparam int GSUM_FULL = GRAD_BITS + COUNT_BITS;
	localparam int WSUM_BITS = (WSUM_FULL > 64) ? 64 : WSUM_FULL;
	localparam int GSUM_BITS = (GSUM_FULL > 64) ? 64 : GSUM_FULL;
	localparam int PROD_BITS = PIXEL_BITS + GRAD_BITS;

	// classify product is split into two partial products over the gradient sum
	localparam int GLO_BITS = (GSUM_BITS + 1) / 2;
	localparam int GHI_BITS = GSUM_BITS - GLO_BITS;
	localparam int CMP_BITS = PIXEL_BITS + GSUM_BITS;

	localparam int IQ_DEPTH  = 4;
	localparam int OUT_DEPTH = 4;

	localparam logic [KIND_W-1:0] KIND_ACC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLS  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]     op;
		logic [PIXEL_BITS-1:0] pix;
		logic [GRAD_BITS-1:0]  grad;
		logic [PROD_BITS-1:0]  prod;
	} entry_t;

endpackage

@@ hdl/gradient_weighted_threshold.sv @@
// top level of the gradient weighted threshold block
`timescale 1ns / 1ps
// Takes one request per clock while full is low: accumulate adds pixel*gradient and the
// gradient into two saturating sums, classify returns mask_bit = 1 unless pixel*gradient_sum
// is below the weighted sum (a zero gradient sum gives 1), clear zeroes both sums, and code 3
// is ignored. Requests enter a four-entry queue after the front end's pixel*gradient multiply;
// the back end applies accumulates in a combinational saturating add on the sum registers, so
// one request per cycle is sustained in any mix while results are popped. A classify result
// passes the front queue write, sum snapshot, split multiply and result queue write before it
// is on the outputs, and waits in a four-entry result queue; when that queue backs up, a
// classify at the head of the front queue stalls together with every request behind it, and
// full rises once the front queue fills.
module gradient_weighted_threshold (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [gwt_pkg::KIND_W-1:0] kind,
	input  logic [gwt_pkg::PIX_W-1:0]  pixel_value,
	input  logic [gwt_pkg::GRAD_W-1:0] gradient_magnitude,
	output logic                       empty,
	input  logic                       pop,
	output logic                       mask_bit
);
	import gwt_pkg::*;

	entry_t head;
	logic   head_valid;
	logic   head_pop;

	gwt_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.kind               (kind),
		.pixel_value        (pixel_value),
		.gradient_magnitude (gradient_magnitude),
		.head_pop           (head_pop),
		.head_valid         (head_valid),
		.head               (head)
	);

	gwt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.mask_bit   (mask_bit)
	);

endmodule

@@ hdl/gwt_front.sv @@
// front end: accepts requests, drops unused codes, forms pixel*gradient and queues the work
`timescale 1ns / 1ps
module gwt_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [gwt_pkg::KIND_W-1:0] kind,
	input  logic [gwt_pkg::PIX_W-1:0]  pixel_value,
	input  logic [gwt_pkg::GRAD_W-1:0] gradient_magnitude,
	input  logic                       head_pop,
	output logic                       head_valid,
	output gwt_pkg::entry_t            head
);
	import gwt_pkg::*;

	localparam int PTR_W = $clog2(IQ_DEPTH);
	localparam int CNT_W = $clog2(IQ_DEPTH + 1);

	entry_t             mem_q [IQ_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	entry_t             new_entry;
	logic               accept;
	logic               wr_en;
	logic               rd_en;

	assign full       = (cnt_q == CNT_W'(IQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign accept     = push && !full;
	assign wr_en      = accept && (kind != KIND_NONE);
	assign rd_en      = head_pop && head_valid;

	always_comb begin
		new_entry.op   = kind;
		new_entry.pix  = PIXEL_BITS'(pixel_value);
		new_entry.grad = GRAD_BITS'(gradient_magnitude);
		new_entry.prod = PROD_BITS'(PIXEL_BITS'(pixel_value))
			* PROD_BITS'(GRAD_BITS'(gradient_magnitude));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(IQ_DEPTH))
		else $error("front queue count beyond depth");
	a_drop_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_NONE && !rd_en) |=> $stable(cnt_q))
		else $error("unused code entered the front queue");
	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !rd_en)
		else $error("pop from empty front queue");

endmodule

@@ hdl/gwt_back.sv @@
// back end: saturating sums, two-stage classify multiply and the result queue
`timescale 1ns / 1ps
module gwt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  gwt_pkg::entry_t head,
	output logic            head_pop,
	output logic            empty,
	input  logic            pop,
	output logic            mask_bit
);
	import gwt_pkg::*;

	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
	localparam int OSUM_W = $clog2(OUT_DEPTH + 3);

	logic [WSUM_BITS-1:0]  wsum_q;
	logic [GSUM_BITS-1:0]  gsum_q;
	logic [WSUM_BITS:0]    wsum_add;
	logic [GSUM_BITS:0]    gsum_add;

	logic                  v_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [GSUM_BITS-1:0]  gsum_s1;
	logic [WSUM_BITS-1:0]  wsum_s1;

	logic                            v_s2;
	logic [PIXEL_BITS+GLO_BITS-1:0]  plo_s2;
	logic [PIXEL_BITS+GHI_BITS-1:0]  phi_s2;
	logic [WSUM_BITS-1:0]            wsum_s2;
	logic                            zero_s2;
	logic [CMP_BITS-1:0]             prod_full;
	logic                            res_bit;

	logic              omem_q [OUT_DEPTH];
	logic [OPTR_W-1:0] owr_q;
	logic [OPTR_W-1:0] ord_q;
	logic [OCNT_W-1:0] ocnt_q;
	logic [OSUM_W-1:0] occupancy;
	logic              credit_ok;
	logic              head_is_cls;
	logic              take;
	logic              opush;
	logic              opop;

	// classify results must all find room in the result queue
	assign occupancy   = OSUM_W'(ocnt_q) + OSUM_W'(v_s1) + OSUM_W'(v_s2);
	assign credit_ok   = (occupancy < OSUM_W'(OUT_DEPTH));
	assign head_is_cls = (head.op == KIND_CLS);
	assign head_pop    = head_valid && (!head_is_cls || credit_ok);
	assign take        = head_pop;

	assign wsum_add = {1'b0, wsum_q} + (WSUM_BITS + 1)'(head.prod);
	assign gsum_add = {1'b0, gsum_q} + (GSUM_BITS + 1)'(head.grad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			gsum_q <= '0;
		end else if (take) begin
			unique case (head.op)
				KIND_ACC: begin
					wsum_q <= wsum_add[WSUM_BITS] ? '1 : wsum_add[WSUM_BITS-1:0];
					gsum_q <= gsum_add[GSUM_BITS] ? '1 : gsum_add[GSUM_BITS-1:0];
				end
				KIND_CLR: begin
					wsum_q <= '0;
					gsum_q <= '0;
				end
				default: begin
					wsum_q <= wsum_q;
					gsum_q <= gsum_q;
				end
			endcase
		end
	end

	// sums are snapshotted in order with the accumulate stream
	always_ff @(posedge clk) begin
		pix_s1  <= head.pix;
		gsum_s1 <= gsum_q;
		wsum_s1 <= wsum_q;
		plo_s2  <= (PIXEL_BITS + GLO_BITS)'(pix_s1)
			* (PIXEL_BITS + GLO_BITS)'(gsum_s1[GLO_BITS-1:0]);
		phi_s2  <= (PIXEL_BITS + GHI_BITS)'(pix_s1)
			* (PIXEL_BITS + GHI_BITS)'(gsum_s1[GSUM_BITS-1:GLO_BITS]);
		wsum_s2 <= wsum_s1;
		zero_s2 <= (gsum_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take && head_is_cls;
			v_s2 <= v_s1;
		end
	end

	assign prod_full = CMP_BITS'(plo_s2) + (CMP_BITS'(phi_s2) << GLO_BITS);
	assign res_bit   = zero_s2 || !(prod_full < CMP_BITS'(wsum_s2));

	assign opush    = v_s2;
	assign opop     = pop && !empty;
	assign empty    = (ocnt_q == '0);
	assign mask_bit = omem_q[ord_q];

	always_ff @(posedge clk) begin
		if (opush) begin
			omem_q[owr_q] <= res_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owr_q <= owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= ord_q + 1'b1;
			end
			unique case ({opush, opop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= OSUM_W'(OUT_DEPTH))
		else $error("more classify results in flight than result slots");
	a_no_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> (ocnt_q != OCNT_W'(OUT_DEPTH)) || opop)
		else $error("result pushed into a full queue");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.op == KIND_CLR) |=> (wsum_q == '0 && gsum_q == '0))
		else $error("clear did not zero the sums");
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(take && head.op == KIND_CLR) |=> (wsum_q >= $past(wsum_q)
			&& gsum_q >= $past(gsum_q)))
		else $error("sum decreased without a clear");

endmodule

@@ test/gradient_weighted_threshold_tb.sv @@
// testbench for the gradient weighted threshold block: directed and random requests, self-checked
`timescale 1ns / 1ps
module gradient_weighted_threshold_tb;
	import gwt_pkg::*;

	localparam int          RANDOM_ITEMS = 1000;
	localparam int          BURST_ITEMS  = 64;
	localparam int          DRAIN_CYCLES = 16;
	localparam longint      CYCLE_LIMIT  = 200000;
	localparam logic [63:0] WSUM_MAX     = (64'd1 << WSUM_BITS) - 64'd1;
	localparam logic [63:0] GSUM_MAX     = (64'd1 << GSUM_BITS) - 64'd1;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [KIND_W-1:0] kind;
	logic [PIX_W-1:0]  pixel_value;
	logic [GRAD_W-1:0] gradient_magnitude;
	logic              empty;
	logic              pop;
	logic              mask_bit;

	// model copy of the two sums
	logic [WSUM_BITS-1:0] wsum_model;
	logic [GSUM_BITS-1:0] gsum_model;
	logic                 mask_expected[$];

	int     mismatch_count;
	int     live_requests;
	longint cycle_count;
	bit     quiet;

	gradient_weighted_threshold i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.kind               (kind),
		.pixel_value        (pixel_value),
		.gradient_magnitude (gradient_magnitude),
		.empty              (empty),
		.pop                (pop),
		.mask_bit           (mask_bit)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	function automatic void predict_request(input logic [KIND_W-1:0] req_kind,
			input logic [PIX_W-1:0] req_pix, input logic [GRAD_W-1:0] req_grad);
		logic [63:0] total;
		logic        mask;
		case (req_kind)
		KIND_ACC: begin
			total = 64'(wsum_model) + 64'(req_pix) * 64'(req_grad);
			wsum_model = (total > WSUM_MAX) ? WSUM_MAX[WSUM_BITS-1:0] : total[WSUM_BITS-1:0];
			total = 64'(gsum_model) + 64'(req_grad);
			gsum_model = (total > GSUM_MAX) ? GSUM_MAX[GSUM_BITS-1:0] : total[GSUM_BITS-1:0];
		end
		KIND_CLS: begin
			// an empty gradient sum leaves the threshold undefined, so never below it
			mask = 1'b1;
			if (gsum_model != 0 && 64'(req_pix) * 64'(gsum_model) < 64'(wsum_model))
				mask = 1'b0;
			mask_expected.insert(mask_expected.size(), mask);
		end
		KIND_CLR: begin
			wsum_model = '0;
			gsum_model = '0;
		end
		default: ;
		endcase
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] req_kind, input logic [PIX_W-1:0] req_pix,
			input logic [GRAD_W-1:0] req_grad);
		int gap;
		@(negedge clk);
		push               <= 1'b1;
		kind               <= req_kind;
		pixel_value        <= req_pix;
		gradient_magnitude <= req_grad;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		predict_request(req_kind, req_pix, req_grad);
		if (req_kind != KIND_NONE)
			live_requests++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop sending and let every outstanding classify come back
	task automatic wait_results_done();
		@(negedge clk);
		push <= 1'b0;
		while (mask_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result side: random stall bursts unless quiet
	initial begin
		int stall_left;
		logic next_pop;
		stall_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				next_pop = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				next_pop = 1'b0;
			end else begin
				next_pop = 1'b1;
			end
			pop <= next_pop;
		end
	end

	always @(posedge clk) begin
		logic want;
		if (arst_n && pop && !empty) begin
			if (mask_expected.size() == 0) begin
				report_mismatch($sformatf("mask_bit %0b with no classify waiting", mask_bit));
			end else begin
				want = mask_expected.pop_front();
				if (mask_bit !== want)
					report_mismatch($sformatf("mask_bit %0b, expected %0b", mask_bit, want));
			end
		end
	end

	task automatic test_empty_sums();
		send_item(KIND_CLS, 16'd0, 16'd0);
		send_item(KIND_CLS, 16'hffff, 16'hffff);
		send_item(KIND_ACC, 16'd5000, 16'd0);
		send_item(KIND_CLS, 16'd0, 16'd0);
	endtask

	// pixels at and just either side of the weighted mean; exactly at the mean is not below it
	task automatic test_boundary();
		send_item(KIND_ACC, 16'd100, 16'h0100);
		send_item(KIND_CLS, 16'd100, 16'h1234);
		send_item(KIND_CLS, 16'd99, 16'd0);
		send_item(KIND_CLS, 16'd101, 16'd0);
		send_item(KIND_ACC, 16'd300, 16'h0080);
		send_item(KIND_CLS, 16'd166, 16'd0);
		send_item(KIND_CLS, 16'd167, 16'd0);
	endtask

	task automatic test_extremes();
		send_item(KIND_CLR, 16'hffff, 16'hffff);
		send_item(KIND_CLS, 16'd1, 16'd0);
		send_item(KIND_ACC, 16'hffff, 16'hffff);
		send_item(KIND_CLS, 16'hffff, 16'd0);
		send_item(KIND_CLS, 16'hfffe, 16'd0);
		send_item(KIND_ACC, 16'd0, 16'hffff);
		send_item(KIND_CLS, 16'h7fff, 16'd0);
		send_item(KIND_CLS, 16'h8000, 16'd0);
	endtask

	task automatic test_ignored_code();
		send_item(KIND_NONE, 16'hffff, 16'hffff);
		send_item(KIND_NONE, 16'd0, 16'd0);
		send_item(KIND_CLS, 16'h8000, 16'd0);
		send_item(KIND_CLS, 16'h7fff, 16'd0);
	endtask

	// back-to-back run of largest products with no idling on either side
	task automatic test_peak_burst();
		quiet = 1'b1;
		send_item(KIND_CLR, 16'd0, 16'd0);
		repeat (BURST_ITEMS) send_item(KIND_ACC, 16'hffff, 16'hffff);
		send_item(KIND_CLS, 16'hffff, 16'd0);
		send_item(KIND_CLS, 16'd0, 16'd0);
		send_item(KIND_ACC, 16'hffff, 16'hffff);
		send_item(KIND_ACC, 16'd1, 16'd1);
		send_item(KIND_CLS, 16'hffff, 16'd0);
		send_item(KIND_CLR, 16'd0, 16'd0);
		send_item(KIND_CLS, 16'd0, 16'd0);
		quiet = 1'b0;
		wait_results_done();
	endtask

	task automatic test_random_passes();
		int          start;
		int          n;
		bit          drained;
		logic [63:0] mean;
		logic [15:0] pix;
		logic [15:0] grad;
		start = live_requests;
		drained = 1'b0;
		while (live_requests - start < RANDOM_ITEMS) begin
			quiet = (live_requests - start) > RANDOM_ITEMS * 85 / 100;
			if ($urandom_range(0, 2) == 0)
				send_item(KIND_CLR, 16'($urandom), 16'($urandom));
			// accumulate pass
			n = $urandom_range(1, 16);
			repeat (n) begin
				case ($urandom_range(0, 3))
				0: pix = 16'($urandom_range(0, 255));
				1: pix = 16'hffff;
				default: pix = 16'($urandom);
				endcase
				case ($urandom_range(0, 3))
				0: grad = 16'($urandom_range(0, 511));
				1: grad = 16'hffff;
				2: grad = 16'd0;
				default: grad = 16'($urandom);
				endcase
				send_item(KIND_ACC, pix, grad);
				if ($urandom_range(0, 15) == 0)
					send_item(KIND_NONE, 16'($urandom), 16'($urandom));
			end
			// classify pass, mostly close to the current threshold
			n = $urandom_range(1, 8);
			repeat (n) begin
				if (gsum_model != 0 && $urandom_range(0, 3) != 0) begin
					mean = 64'(wsum_model) / 64'(gsum_model);
					mean = mean + 64'($urandom_range(0, 4)) - 64'd2;
					if (mean > 64'hffff && mean < 64'hffff_0000)
						mean = 64'hffff;
					else if (mean >= 64'hffff_0000)
						mean = 64'd0;
					pix = mean[15:0];
				end else begin
					pix = 16'($urandom);
				end
				send_item(KIND_CLS, pix, 16'($urandom));
			end
			// broken pass: arbitrary codes in any order
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
			end
			if (!drained && live_requests - start > RANDOM_ITEMS / 2) begin
				drained = 1'b1;
				wait_results_done();
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		push               = 1'b0;
		kind               = KIND_ACC;
		pixel_value        = '0;
		gradient_magnitude = '0;
		wsum_model         = '0;
		gsum_model         = '0;
		mismatch_count     = 0;
		live_requests      = 0;
		cycle_count        = 0;
		quiet              = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_sums();
		test_boundary();
		test_extremes();
		test_ignored_code();
		wait_results_done();
		test_peak_burst();
		test_random_passes();
		wait_results_done();

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
